// ===== design/cpr_pkg.sv =====
// clock page replacement: shared constants, payload words, state codes and helpers
// no dependencies; the design files refer to this package by scoped names, the testbench imports it
`default_nettype none

package cpr_pkg;

	// sizing of the replacement unit
	localparam int NUM_FRAMES     = 32;
	localparam int PAGE_WORDS     = 16;
	localparam int NUM_PROCS      = 16;
	localparam int PAGES_PER_PROC = 16;

	// field widths of the words on the channels
	localparam int PROC_W  = 4;
	localparam int PAGE_W  = 4;
	localparam int OFF_W   = 4;
	localparam int FRAME_W = 5;
	localparam int PHYS_W  = 9;

	// page map geometry
	localparam int MAP_DEPTH = NUM_PROCS * PAGES_PER_PROC;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);

	typedef struct packed {
		logic [PROC_W-1:0] proc_id;
		logic [PAGE_W-1:0] virt_page;
		logic [OFF_W-1:0]  page_offset;
	} req_word_t;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame_num;
		logic [PHYS_W-1:0]  phys_index;
		logic               evicted;
		logic [PROC_W-1:0]  evicted_proc;
		logic [PAGE_W-1:0]  evicted_page;
	} rsp_word_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SWEEP,
		ST_EVICT
	} state_t;

	// result of the find-first unit
	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] idx;
	} ffz_res_t;

	// page map update port: one mapping written, one old mapping dropped
	typedef struct packed {
		logic              wr_en;
		logic [MAP_AW-1:0] wr_addr;
		logic [FRAME_W-1:0] wr_frame;
		logic              inv_en;
		logic [MAP_AW-1:0] inv_addr;
	} map_upd_t;

	// page map index of a process and page
	function automatic logic [MAP_AW-1:0] map_addr(input logic [PROC_W-1:0] proc,
			input logic [PAGE_W-1:0] page);
		logic [31:0] p;
		logic [31:0] g;
		p = 32'(proc) % NUM_PROCS;
		g = 32'(page) % PAGES_PER_PROC;
		return MAP_AW'(p * PAGES_PER_PROC + g);
	endfunction

	// physical word index of a frame and offset
	function automatic logic [PHYS_W-1:0] phys_addr(input logic [FRAME_W-1:0] frame,
			input logic [OFF_W-1:0] off);
		logic [31:0] o;
		o = 32'(off) % PAGE_WORDS;
		return PHYS_W'(32'(frame) * PAGE_WORDS + o);
	endfunction

endpackage

`default_nettype wire

// ===== design/cpr_req_if.sv =====
// request channel: valid/ready handshake carrying one access word
// depends on cpr_pkg for the payload type
`default_nettype none

interface cpr_req_if;
	logic                valid;
	logic                ready;
	cpr_pkg::req_word_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cpr_rsp_if.sv =====
// response channel: valid/ready handshake carrying one result word
// depends on cpr_pkg for the payload type
`default_nettype none

interface cpr_rsp_if;
	logic                valid;
	logic                ready;
	cpr_pkg::rsp_word_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cpr_ffz.sv =====
// find-first unit: lowest frame index among candidate frames
// shared by the forward scan and the wrap sweep; uses cpr_pkg
`default_nettype none

module cpr_ffz (
	input  wire logic [cpr_pkg::NUM_FRAMES-1:0] cand,
	output cpr_pkg::ffz_res_t                   res
);

	// priority encode, lowest index wins
	always_comb begin
		res = '0;
		for (int i = cpr_pkg::NUM_FRAMES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				res.found = 1'b1;
				res.idx   = cpr_pkg::FRAME_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/cpr_map.sv =====
// page map: frame number memory with registered read, present bits in flops
// uses cpr_pkg for geometry and the update struct
`default_nettype none

module cpr_map (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rd_en,
	input  wire logic [cpr_pkg::MAP_AW-1:0]     rd_addr,
	output logic                                rd_valid,
	output logic [cpr_pkg::FRAME_W-1:0]         rd_frame,
	input  cpr_pkg::map_upd_t                   upd
);

	logic [cpr_pkg::FRAME_W-1:0]   frame_mem [cpr_pkg::MAP_DEPTH];
	logic [cpr_pkg::MAP_DEPTH-1:0] present_q;
	logic                          rd_valid_q;
	logic [cpr_pkg::FRAME_W-1:0]   rd_frame_q;

	// frame memory, written on a fault, read on every access
	always_ff @(posedge clk) begin
		if (upd.wr_en)
			frame_mem[upd.wr_addr] <= upd.wr_frame;
		if (rd_en)
			rd_frame_q <= frame_mem[rd_addr];
	end

	// present bits; a new mapping wins over a dropped one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (upd.inv_en)
				present_q[upd.inv_addr] <= 1'b0;
			if (upd.wr_en)
				present_q[upd.wr_addr] <= 1'b1;
			if (rd_en)
				rd_valid_q <= present_q[rd_addr];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_frame = rd_frame_q;

endmodule

`default_nettype wire

// ===== design/clock_page_replacement_core.sv =====
// clock page replacement core: sequencer, frame owners, reference bits, hand
// a hit is loaded into the result register from ST_LOOK, a fault found ahead of
// the hand via ST_EVICT, a wrap sweep via ST_SWEEP then ST_EVICT; a full result
// register holds ST_LOOK and ST_EVICT; one item in flight at a time
// reset clears state, hand, reference bits, owner and page map present bits at once
// depends on cpr_pkg, cpr_req_if, cpr_rsp_if, cpr_ffz, cpr_map
`default_nettype none

module clock_page_replacement_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cpr_req_if.sink    req,
	cpr_rsp_if.source  rsp
);

	localparam int NF = cpr_pkg::NUM_FRAMES;
	localparam int FW = cpr_pkg::FRAME_W;

	cpr_pkg::state_t    state_q, state_d;
	cpr_pkg::req_word_t req_q;
	cpr_pkg::rsp_word_t rsp_q, emit_word;
	logic               rsp_valid_q;
	logic [NF-1:0]      ref_q, ref_d;
	logic [FW-1:0]      hand_q;
	logic [FW-1:0]      victim_q, victim_d;
	logic [NF-1:0]      own_valid_q;
	logic [cpr_pkg::PROC_W-1:0] own_proc_q [NF];
	logic [cpr_pkg::PAGE_W-1:0] own_page_q [NF];

	logic               accept;
	logic               slot_free;
	logic               emit;
	logic               evict_go;
	logic [NF-1:0]      hi_mask;
	logic [NF-1:0]      below_mask;
	logic [NF-1:0]      cand;
	cpr_pkg::ffz_res_t  ffz;
	logic               map_valid;
	logic [FW-1:0]      map_frame;
	cpr_pkg::map_upd_t  upd;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == cpr_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;

	// page map lookup issued with the accepted word
	cpr_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (cpr_pkg::map_addr(req.data.proc_id, req.data.virt_page)),
		.rd_valid (map_valid),
		.rd_frame (map_frame),
		.upd      (upd)
	);

	// window mask relative to the hand
	always_comb begin
		for (int f = 0; f < NF; f++) begin
			hi_mask[f] = (FW'(f) >= hand_q);
		end
	end

	// window mask below the found frame
	always_comb begin
		for (int f = 0; f < NF; f++) begin
			below_mask[f] = (FW'(f) < ffz.idx);
		end
	end

	// forward scan looks at or past the hand, the sweep looks below it
	assign cand = ~ref_q & ((state_q == cpr_pkg::ST_SWEEP) ? ~hi_mask : hi_mask);

	cpr_ffz u_ffz (
		.cand (cand),
		.res  (ffz)
	);

	// sequencer: next state, reference bits and result word
	always_comb begin
		state_d   = state_q;
		victim_d  = victim_q;
		ref_d     = ref_q;
		emit      = 1'b0;
		evict_go  = 1'b0;
		emit_word = '0;
		unique case (state_q)
			cpr_pkg::ST_IDLE: begin
				if (accept)
					state_d = cpr_pkg::ST_LOOK;
			end
			cpr_pkg::ST_LOOK: begin
				if (map_valid) begin
					if (slot_free) begin
						emit                 = 1'b1;
						emit_word.hit        = 1'b1;
						emit_word.frame_num  = map_frame;
						emit_word.phys_index = cpr_pkg::phys_addr(map_frame, req_q.page_offset);
						ref_d[map_frame]     = 1'b1;
						state_d              = cpr_pkg::ST_IDLE;
					end
				end else if (ffz.found) begin
					victim_d = ffz.idx;
					state_d  = cpr_pkg::ST_EVICT;
				end else begin
					state_d = cpr_pkg::ST_SWEEP;
				end
			end
			cpr_pkg::ST_SWEEP: begin
				// bits from the hand up, and below the found frame, lose their chance
				if (ffz.found) begin
					victim_d = ffz.idx;
					ref_d    = ref_q & ~(hi_mask | below_mask);
				end else begin
					victim_d = hand_q;
					ref_d    = '0;
				end
				state_d = cpr_pkg::ST_EVICT;
			end
			cpr_pkg::ST_EVICT: begin
				if (slot_free) begin
					emit                 = 1'b1;
					evict_go             = 1'b1;
					emit_word.frame_num  = victim_q;
					emit_word.phys_index = cpr_pkg::phys_addr(victim_q, req_q.page_offset);
					if (own_valid_q[victim_q]) begin
						emit_word.evicted      = 1'b1;
						emit_word.evicted_proc = own_proc_q[victim_q];
						emit_word.evicted_page = own_page_q[victim_q];
					end
					ref_d[victim_q] = 1'b1;
					state_d         = cpr_pkg::ST_IDLE;
				end
			end
			default: state_d = cpr_pkg::ST_IDLE;
		endcase
	end

	// page map update on a fault; the old owner's mapping always points here
	always_comb begin
		upd          = '0;
		upd.wr_en    = evict_go;
		upd.wr_addr  = cpr_pkg::map_addr(req_q.proc_id, req_q.virt_page);
		upd.wr_frame = victim_q;
		upd.inv_en   = evict_go && own_valid_q[victim_q];
		upd.inv_addr = cpr_pkg::map_addr(own_proc_q[victim_q], own_page_q[victim_q]);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpr_pkg::ST_IDLE;
			ref_q       <= '0;
			hand_q      <= '0;
			own_valid_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ref_q   <= ref_d;
			if (evict_go) begin
				hand_q                <= victim_q + FW'(1);
				own_valid_q[victim_q] <= 1'b1;
			end
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept)
			req_q <= req.data;
		victim_q <= victim_d;
		if (evict_go) begin
			own_proc_q[victim_q] <= req_q.proc_id;
			own_page_q[victim_q] <= req_q.virt_page;
		end
		if (emit)
			rsp_q <= emit_word;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// the frame taken on a fault never carries a set reference bit
	a_victim_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cpr_pkg::ST_EVICT) |-> !ref_q[victim_q])
		else $error("victim frame has its reference bit set");

	// after a fault the hand sits just past the frame taken
	a_hand_moves: assert property (@(posedge clk) disable iff (!arst_n)
		evict_go |=> (hand_q == $past(victim_q + FW'(1))))
		else $error("hand not advanced past victim");

	// a hit never reports a displaced page
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_word.hit) |-> !emit_word.evicted)
		else $error("hit word flags an eviction");

	// the frame in every result word is marked referenced afterwards
	a_ref_set: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> ref_q[$past(emit_word.frame_num)])
		else $error("reference bit not set for returned frame");

	// no new word is taken while an access is still being worked on
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while busy");

endmodule

`default_nettype wire

// ===== tb/tb_clock_page_replacement_core.sv =====
// testbench for clock_page_replacement_core: directed and random access streams, results
// checked word by word against a second-chance page replacement predictor held in the bench
// depends on cpr_pkg, cpr_req_if, cpr_rsp_if and the core itself
`default_nettype none

module tb_clock_page_replacement_core;
	timeunit 1ns;
	timeprecision 1ps;

	import cpr_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int TARGET_ACCESSES = 850;
	localparam int MAX_REPORTS     = 10;

	logic clk;
	logic arst_n;

	cpr_req_if req_ch();
	cpr_rsp_if rsp_ch();

	clock_page_replacement_core uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// predictor copy of the page tables and clock state
	bit                 map_on   [MAP_DEPTH];
	logic [FRAME_W-1:0] map_frm  [MAP_DEPTH];
	bit                 own_on   [NUM_FRAMES];
	logic [PROC_W-1:0]  own_proc [NUM_FRAMES];
	logic [PAGE_W-1:0]  own_page [NUM_FRAMES];
	bit                 refd     [NUM_FRAMES];
	int                 clock_hand;

	rsp_word_t pending_translations[$];

	int  cycle_count;
	int  accesses;
	int  hit_count;
	int  fault_count;
	int  evict_count;
	int  wrap_sweeps;
	int  hold_offs;
	int  mismatches;
	bit  tx_steady;
	bit  rx_steady;
	int  hold_left;
	int  stall_left;

	// clock and cycle counter
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	// timeout guard
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_translations.size());
		$display("clock_page_replacement_core test failed");
		$finish;
	end

	// predict one access and update the clock state
	function automatic rsp_word_t translate_access(input req_word_t w);
		rsp_word_t r;
		int        proc;
		int        page;
		int        idx;
		int        f;
		int        k;
		int        n;
		int        oi;
		r    = '0;
		proc = int'(w.proc_id) % NUM_PROCS;
		page = int'(w.virt_page) % PAGES_PER_PROC;
		idx  = proc * PAGES_PER_PROC + page;
		if (map_on[idx]) begin
			r.hit = 1'b1;
			f = int'(map_frm[idx]);
			refd[f] = 1'b1;
			hit_count++;
		end else begin
			fault_count++;
			// look ahead of the hand without touching bits
			f = -1;
			for (k = clock_hand; k < NUM_FRAMES; k++) begin
				if (f < 0 && !refd[k])
					f = k;
			end
			// second-chance sweep with wrap, clearing as it goes
			if (f < 0) begin
				wrap_sweeps++;
				k = clock_hand;
				for (n = 0; n <= NUM_FRAMES; n++) begin
					if (f < 0) begin
						if (!refd[k]) begin
							f = k;
						end else begin
							refd[k] = 1'b0;
							k = (k + 1) % NUM_FRAMES;
						end
					end
				end
				if (f < 0)
					f = k;
			end
			// drop the previous owner's mapping
			if (own_on[f]) begin
				evict_count++;
				r.evicted      = 1'b1;
				r.evicted_proc = own_proc[f];
				r.evicted_page = own_page[f];
				oi = int'(own_proc[f]) * PAGES_PER_PROC + int'(own_page[f]);
				if (map_on[oi] && int'(map_frm[oi]) == f)
					map_on[oi] = 1'b0;
			end
			own_on[f]   = 1'b1;
			own_proc[f] = PROC_W'(proc);
			own_page[f] = PAGE_W'(page);
			refd[f]     = 1'b1;
			map_on[idx]  = 1'b1;
			map_frm[idx] = FRAME_W'(f);
			clock_hand   = (f + 1) % NUM_FRAMES;
		end
		r.frame_num  = FRAME_W'(f);
		r.phys_index = PHYS_W'(f * PAGE_WORDS + int'(w.page_offset) % PAGE_WORDS);
		return r;
	endfunction

	function automatic req_word_t make_access(input int proc, input int page, input int off);
		req_word_t w;
		w.proc_id     = PROC_W'(proc);
		w.virt_page   = PAGE_W'(page);
		w.page_offset = OFF_W'(off);
		return w;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one access word and wait for it to be taken
	task automatic send_access(input req_word_t w);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_translations.push_back(translate_access(w));
		accesses++;
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		pause_sender(1);
		while (pending_translations.size() != 0)
			@(posedge clk);
	endtask

	// receiver: long hold-off on request, else random stalls or steady ready
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else if (rx_steady) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rsp_word_t exp_w;
		rsp_word_t got;
		bit        bad;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.data;
			if (pending_translations.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result word with nothing outstanding: %p", $realtime, got);
			end else begin
				exp_w = pending_translations.pop_front();
				bad = (got.hit !== exp_w.hit) || (got.frame_num !== exp_w.frame_num) ||
					(got.phys_index !== exp_w.phys_index) || (got.evicted !== exp_w.evicted) ||
					(got.evicted_proc !== exp_w.evicted_proc) ||
					(got.evicted_page !== exp_w.evicted_page);
				if (bad) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: mismatch exp hit=%0d frame=%0d phys=%0d ev=%0d evp=%0d evg=%0d",
							$realtime, exp_w.hit, exp_w.frame_num, exp_w.phys_index,
							exp_w.evicted, exp_w.evicted_proc, exp_w.evicted_page);
						$display("%0t:          got hit=%0d frame=%0d phys=%0d ev=%0d evp=%0d evg=%0d",
							$realtime, got.hit, got.frame_num, got.phys_index,
							got.evicted, got.evicted_proc, got.evicted_page);
					end
				end
			end
		end
	end

	// first touches into unowned frames, hits, extreme fields
	task automatic test_first_touch();
		send_access(make_access(0, 0, 0));
		send_access(make_access(0, 0, 15));
		send_access(make_access(15, 15, 15));
		send_access(make_access(15, 15, 0));
		send_access(make_access(0, 15, 1));
		send_access(make_access(15, 0, 14));
		pause_sender(pick_gap());
		send_access(make_access(10, 5, 5));
		send_access(make_access(5, 10, 10));
		send_access(make_access(0, 0, 7));
		send_access(make_access(15, 15, 8));
		send_access(make_access(1, 2, 3));
		send_access(make_access(3, 2, 1));
		pause_sender(pick_gap());
		send_access(make_access(8, 8, 15));
		send_access(make_access(7, 7, 0));
		send_access(make_access(0, 15, 15));
		send_access(make_access(15, 0, 0));
		send_access(make_access(12, 3, 9));
		send_access(make_access(3, 12, 6));
		send_access(make_access(10, 5, 0));
		drain_results();
	endtask

	// fill every frame, then fault with all bits set and re-touch the displaced page
	task automatic test_full_sweep();
		int  key;
		int  free_frames;
		int  victim_key;
		do begin
			do
				key = $urandom_range(0, MAP_DEPTH - 1);
			while (map_on[key]);
			send_access(make_access(key >> PAGE_W, key, $urandom_range(0, 15)));
			pause_sender(pick_gap());
			free_frames = 0;
			foreach (own_on[i])
				if (!own_on[i])
					free_frames++;
		end while (free_frames != 0);
		victim_key = int'(own_proc[clock_hand]) * PAGES_PER_PROC + int'(own_page[clock_hand]);
		do
			key = $urandom_range(0, MAP_DEPTH - 1);
		while (map_on[key]);
		send_access(make_access(key >> PAGE_W, key, 15));
		send_access(make_access(key >> PAGE_W, key, 0));
		send_access(make_access(victim_key >> PAGE_W, victim_key, 0));
		send_access(make_access(victim_key >> PAGE_W, victim_key, 15));
		drain_results();
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_back_pressure();
		hold_left = 300;
		hold_offs++;
		repeat (12)
			send_access(make_access($urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 15)));
		drain_results();
	endtask

	// random working sets of varying size with some uniform noise
	task automatic test_working_sets();
		int pool[$];
		int sizes[8] = '{3, 12, 28, 32, 36, 60, 140, 256};
		int size;
		int len;
		int key;
		int phase;
		phase = 0;
		while (accesses < TARGET_ACCESSES) begin
			size = sizes[$urandom_range(0, 7)];
			len  = $urandom_range(40, 90);
			pool.delete();
			repeat (size)
				pool.push_back($urandom_range(0, MAP_DEPTH - 1));
			tx_steady = (phase % 4 == 3);
			rx_steady = tx_steady;
			repeat (len) begin
				if ($urandom_range(0, 9) == 0)
					key = $urandom_range(0, MAP_DEPTH - 1);
				else
					key = pool[$urandom_range(0, size - 1)];
				send_access(make_access(key >> PAGE_W, key, $urandom_range(0, 15)));
				if (!tx_steady)
					pause_sender(pick_gap());
			end
			phase++;
			if (phase % 3 == 0)
				drain_results();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// main sequence
	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		clock_hand   = 0;
		hold_left    = 0;
		stall_left   = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_first_touch();
		test_full_sweep();
		test_back_pressure();
		test_working_sets();

		drain_results();
		repeat (8) @(posedge clk);

		$display("ran %0d accesses: %0d hits, %0d faults, %0d evictions, %0d wrap sweeps",
			accesses, hit_count, fault_count, evict_count, wrap_sweeps);
		$display("%0d long receiver hold-offs, %0d mismatching words", hold_offs, mismatches);
		if (mismatches == 0)
			$display("clock_page_replacement_core test passed");
		else
			$display("clock_page_replacement_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
